// ===== src/dsc_pkg.sv =====
// Shared types, constants and the SipRound function for the DNS server cookie check.
// Used by the controller, the datapath, the top level and the checker.
package dsc_pkg;

    localparam int HASH_TAIL_BYTES     = 8;
    localparam int CLIENT_COOKIE_BYTES = 8;

    localparam logic [63:0] SIP_C0 = 64'h736f6d6570736575;
    localparam logic [63:0] SIP_C1 = 64'h646f72616e646f6d;
    localparam logic [63:0] SIP_C2 = 64'h6c7967656e657261;
    localparam logic [63:0] SIP_C3 = 64'h7465646279746573;

    localparam logic [1:0] REG_KEY_LOW      = 2'd0;
    localparam logic [1:0] REG_KEY_HIGH     = 2'd1;
    localparam logic [1:0] REG_NONCE_LENGTH = 2'd2;

    localparam logic [1:0] SEG_ADDRESS = 2'd0;
    localparam logic [1:0] SEG_CLIENT  = 2'd1;
    localparam logic [1:0] SEG_SERVER  = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [1:0] segment;
        logic       last;
    } dsc_in_t;

    typedef struct packed {
        logic        verdict;
        logic [63:0] computed_hash;
    } dsc_out_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_FEED_CC,
        OP_ROUND,
        OP_ROUND_M,
        OP_ROUND_FIN,
        OP_FIN_MSG,
        OP_DONE
    } dsc_op_t;

    typedef struct packed {
        dsc_op_t    op;
        logic [2:0] cc_idx;
    } dsc_cmd_t;

    typedef struct packed {
        logic word_full;
        logic cc_full;
    } dsc_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RND,
        ST_POST,
        ST_FINMSG,
        ST_FRND,
        ST_OUT
    } dsc_state_t;

    typedef logic [3:0][63:0] dsc_lanes_t;

    // One SipRound over the four lanes
    function automatic dsc_lanes_t sip_round(input dsc_lanes_t v);
        logic [63:0] v0, v1, v2, v3;
        v0 = v[0]; v1 = v[1]; v2 = v[2]; v3 = v[3];
        v0 = v0 + v1; v1 = {v1[50:0], v1[63:51]}; v1 = v1 ^ v0; v0 = {v0[31:0], v0[63:32]};
        v2 = v2 + v3; v3 = {v3[47:0], v3[63:48]}; v3 = v3 ^ v2;
        v0 = v0 + v3; v3 = {v3[42:0], v3[63:43]}; v3 = v3 ^ v0;
        v2 = v2 + v1; v1 = {v1[46:0], v1[63:47]}; v1 = v1 ^ v2; v2 = {v2[31:0], v2[63:32]};
        sip_round = {v3, v2, v1, v0};
    endfunction

endpackage

// ===== src/dsc_datapath.sv =====
// Datapath: key registers, SipHash lanes, byte gathering, cookie buffers and result register.
// Depends on dsc_pkg; driven by dsc_controller through dsc_cmd_t.
module dsc_datapath import dsc_pkg::*; #(
    parameter int MAX_SERVER_COOKIE = 32,
    parameter int MAX_ADDRESS_BYTES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  dsc_in_t     in_item,
    input  dsc_cmd_t    cmd,
    output dsc_status_t status,
    output dsc_out_t    result
);
    localparam int AW = $clog2(MAX_ADDRESS_BYTES + 1);
    localparam int SW = $clog2(MAX_SERVER_COOKIE + 2);
    localparam int CW = (SW > 6) ? SW + 1 : 7;

    logic [63:0] key_low_reg, key_high_reg;
    logic [4:0]  nonce_reg;
    dsc_lanes_t  lanes_reg, lanes_next;
    logic [63:0] gather_reg, gather_next;
    logic [5:0]  mc_reg, mc_next;
    logic [AW-1:0] ac_reg, ac_next;
    logic [63:0] ccbuf_reg, ccbuf_next;
    logic [3:0]  ccc_reg, ccc_next;
    logic [SW-1:0] scc_reg, scc_next;
    logic [63:0] rh_reg, rh_next;
    logic        busy_reg, busy_next;
    logic [63:0] m_reg, m_next;
    dsc_out_t    result_reg, result_next;

    dsc_lanes_t  base, rnd;
    logic        fed;
    logic [7:0]  fbyte;
    logic [63:0] gnew, hash, fin_m;
    logic [5:0]  mcnew;
    logic [CW-1:0] need;
    logic        bad;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            nonce_reg    <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_KEY_LOW:      key_low_reg  <= cfg_data;
                REG_KEY_HIGH:     key_high_reg <= cfg_data;
                REG_NONCE_LENGTH: nonce_reg    <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // Work state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gather_reg <= '0;
            mc_reg     <= '0;
            ac_reg     <= '0;
            ccbuf_reg  <= '0;
            ccc_reg    <= '0;
            scc_reg    <= '0;
            rh_reg     <= '0;
            busy_reg   <= 1'b0;
        end else begin
            gather_reg <= gather_next;
            mc_reg     <= mc_next;
            ac_reg     <= ac_next;
            ccbuf_reg  <= ccbuf_next;
            ccc_reg    <= ccc_next;
            scc_reg    <= scc_next;
            rh_reg     <= rh_next;
            busy_reg   <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        lanes_reg  <= lanes_next;
        m_reg      <= m_next;
        result_reg <= result_next;
    end

    // Shared byte feed, round unit and verdict
    always_comb begin
        base = busy_reg ? lanes_reg
             : {key_high_reg ^ SIP_C3, key_low_reg ^ SIP_C2,
                key_high_reg ^ SIP_C1, key_low_reg ^ SIP_C0};
        rnd  = sip_round(lanes_reg);
        fed  = 1'b0;
        fbyte = in_item.data_byte;
        if (cmd.op == OP_FEED_CC) begin
            fbyte = ccbuf_reg[{cmd.cc_idx, 3'b000} +: 8];
            fed   = 1'b1;
        end else if (cmd.op == OP_ACCEPT) begin
            if (in_item.segment == SEG_ADDRESS)
                fed = (ac_reg < AW'(MAX_ADDRESS_BYTES));
            else if (in_item.segment == SEG_SERVER)
                fed = ({{(CW-SW){1'b0}}, scc_reg} < CW'(nonce_reg));
        end
        gnew  = gather_reg | ({56'd0, fbyte} << {mc_reg[2:0], 3'b000});
        mcnew = mc_reg + 6'd1;
        fin_m = gather_reg | {2'b00, mc_reg, 56'd0};
        hash  = lanes_reg[0] ^ lanes_reg[1] ^ lanes_reg[2] ^ lanes_reg[3];
        need  = CW'(nonce_reg) + CW'(HASH_TAIL_BYTES);
        bad   = (ac_reg == '0) || (ccc_reg == 4'd0)
             || (need > CW'(MAX_SERVER_COOKIE))
             || ({{(CW-SW){1'b0}}, scc_reg} != need) || (rh_reg != hash);

        status.word_full = fed && (mcnew[2:0] == 3'd0);
        status.cc_full   = (ccc_reg == 4'(CLIENT_COOKIE_BYTES));

        lanes_next  = lanes_reg;
        gather_next = gather_reg;
        mc_next     = mc_reg;
        ac_next     = ac_reg;
        ccbuf_next  = ccbuf_reg;
        ccc_next    = ccc_reg;
        scc_next    = scc_reg;
        rh_next     = rh_reg;
        busy_next   = busy_reg;
        m_next      = m_reg;
        result_next = result_reg;

        case (cmd.op)
            OP_ACCEPT, OP_FEED_CC: begin
                if (cmd.op == OP_ACCEPT) begin
                    lanes_next = base;
                    busy_next  = 1'b1;
                    if (in_item.segment == SEG_ADDRESS && fed)
                        ac_next = ac_reg + AW'(1);
                    if (in_item.segment == SEG_CLIENT) begin
                        if (ccc_reg < 4'(CLIENT_COOKIE_BYTES))
                            ccbuf_next = ccbuf_reg
                                | ({56'd0, in_item.data_byte} << {ccc_reg[2:0], 3'b000});
                        if (ccc_reg < 4'(CLIENT_COOKIE_BYTES + 1))
                            ccc_next = ccc_reg + 4'd1;
                    end
                    if (in_item.segment == SEG_SERVER) begin
                        if (!fed)
                            rh_next = {in_item.data_byte, rh_reg[63:8]};
                        if (scc_reg < SW'(MAX_SERVER_COOKIE + 1))
                            scc_next = scc_reg + SW'(1);
                    end
                end
                if (fed) begin
                    mc_next     = mcnew;
                    gather_next = gnew;
                    if (status.word_full) begin
                        gather_next = '0;
                        m_next      = gnew;
                        lanes_next[3] = (cmd.op == OP_ACCEPT ? base[3] : lanes_reg[3]) ^ gnew;
                    end
                end
            end
            OP_ROUND:   lanes_next = rnd;
            OP_ROUND_M: begin
                lanes_next    = rnd;
                lanes_next[0] = rnd[0] ^ m_reg;
            end
            OP_ROUND_FIN: begin
                lanes_next    = rnd;
                lanes_next[0] = rnd[0] ^ m_reg;
                lanes_next[2] = rnd[2] ^ 64'hff;
            end
            OP_FIN_MSG: begin
                m_next        = fin_m;
                lanes_next[3] = lanes_reg[3] ^ fin_m;
            end
            OP_DONE: begin
                result_next.verdict       = bad;
                result_next.computed_hash = hash;
                gather_next = '0;
                mc_next     = '0;
                ac_next     = '0;
                ccbuf_next  = '0;
                ccc_next    = '0;
                scc_next    = '0;
                rh_next     = '0;
                busy_next   = 1'b0;
            end
            default: ;
        endcase
    end

    assign result = result_reg;

endmodule

// ===== src/dsc_controller.sv =====
// Controller state machine: sequences byte transfers, compression rounds,
// client cookie feed, finalization and the result transfer. Depends on dsc_pkg.
module dsc_controller import dsc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_last,
    output logic        s_ready,
    output logic        m_valid,
    input  logic        m_ready,
    input  dsc_status_t status,
    output dsc_cmd_t    cmd
);
    dsc_state_t state_reg, state_next;
    logic [2:0] rcnt_reg, rcnt_next;
    logic [3:0] ccidx_reg, ccidx_next;
    logic       lastp_reg, lastp_next;
    logic       mv_reg, mv_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rcnt_reg  <= '0;
            ccidx_reg <= '0;
            lastp_reg <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            rcnt_reg  <= rcnt_next;
            ccidx_reg <= ccidx_next;
            lastp_reg <= lastp_next;
            mv_reg    <= mv_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        rcnt_next  = rcnt_reg;
        ccidx_next = ccidx_reg;
        lastp_next = lastp_reg;
        mv_next    = mv_reg && !m_ready;
        cmd.op     = OP_NONE;
        cmd.cc_idx = ccidx_reg[2:0];
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = OP_ACCEPT;
                    lastp_next = s_last;
                    rcnt_next  = '0;
                    if (status.word_full)
                        state_next = ST_RND;
                    else if (s_last)
                        state_next = ST_POST;
                end
            end
            ST_RND: begin
                rcnt_next = rcnt_reg + 3'd1;
                if (rcnt_reg == 3'd0) begin
                    cmd.op = OP_ROUND;
                end else begin
                    cmd.op     = OP_ROUND_M;
                    state_next = lastp_reg ? ST_POST : ST_IDLE;
                end
            end
            ST_POST: begin
                if (status.cc_full && !ccidx_reg[3]) begin
                    cmd.op     = OP_FEED_CC;
                    ccidx_next = ccidx_reg + 4'd1;
                    rcnt_next  = '0;
                    if (status.word_full)
                        state_next = ST_RND;
                end else begin
                    state_next = ST_FINMSG;
                end
            end
            ST_FINMSG: begin
                cmd.op     = OP_FIN_MSG;
                rcnt_next  = '0;
                state_next = ST_FRND;
            end
            ST_FRND: begin
                rcnt_next = rcnt_reg + 3'd1;
                cmd.op    = (rcnt_reg == 3'd1) ? OP_ROUND_FIN : OP_ROUND;
                if (rcnt_reg == 3'd5)
                    state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!mv_reg || m_ready) begin
                    cmd.op     = OP_DONE;
                    mv_next    = 1'b1;
                    ccidx_next = '0;
                    lastp_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_valid = mv_reg;

endmodule

// ===== src/dns_server_cookie_check.sv =====
// DNS server cookie check: takes one request as a byte stream (address, client
// cookie, server cookie, last byte flagged) and returns one verdict plus the
// SipHash-2-4 value per request. A byte is taken whenever the controller is idle;
// every byte that completes an 8-byte word runs two rounds on the single shared
// SipRound unit, and input is blocked meanwhile. After the last byte the block
// closes the byte feed; with an exactly eight-byte client cookie it first feeds
// the buffered cookie, again with two rounds per completed word. Then it runs
// the SipHash finalization and loads the result register. Input is accepted
// while a previous result waits for m_ready; a new result waits in the output
// state until that one is taken.
// Keys are loaded into the lanes on the first byte of each request.
// Configuration: index 0 key_low, 1 key_high, 2 nonce_length; writes are always taken.
module dns_server_cookie_check import dsc_pkg::*; #(
    parameter int MAX_SERVER_COOKIE = 32,
    parameter int MAX_ADDRESS_BYTES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  dsc_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output dsc_out_t    m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    dsc_cmd_t    cmd;
    dsc_status_t status;

    assign cfg_ready = 1'b1;

    dsc_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_data.last),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    dsc_datapath #(
        .MAX_SERVER_COOKIE (MAX_SERVER_COOKIE),
        .MAX_ADDRESS_BYTES (MAX_ADDRESS_BYTES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (s_data),
        .cmd       (cmd),
        .status    (status),
        .result    (m_data)
    );

endmodule

// ===== src/dsc_checker.sv =====
// Port-level checker for dns_server_cookie_check, bound to the top level.
// Depends on dsc_pkg for the payload types.
module dsc_checker import dsc_pkg::*; (
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input dsc_in_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input dsc_out_t m_data
);
    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // No result pending right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Stop input transfers once the final byte is taken
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.last |=> !s_ready)
        else $error("input taken during finalization");

    // A new result follows a busy period
    a_rise: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared without finalization");
endmodule

bind dns_server_cookie_check dsc_checker u_dsc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
